@@ design/assert_macros.svh @@
// Assertion macros for the vertex weld design files.
// Requires clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequence must hold in the same cycle as the condition.
`define VWH_ASSERT_NOW(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// The consequence must hold in the cycle after the condition.
`define VWH_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

@@ design/vwh_pkg.sv @@
`timescale 1ns / 1ps
// Package for the vertex weld block: sizes, register codes and storage words.
// No dependencies; used by the interfaces and by every module except vwh_ram.
package vwh_pkg;

    localparam int MAX_VERTICES = 4096;
    localparam int BUCKET_SLOTS = 1024;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int NEXT_W       = IDX_W + 1;
    localparam int BKT_W        = $clog2(BUCKET_SLOTS);
    localparam int BCNT_W       = 11;
    localparam int SCALE_W      = 16;
    localparam int TOL_W        = 16;
    localparam int COORD_W      = 32;
    localparam int OUT_IDX_W    = 12;
    localparam int SUM_W        = 35;
    localparam int PROD_W       = SUM_W + SCALE_W;
    localparam int ROUND_SHIFT  = 16;
    localparam int REM_W        = BKT_W + 1;
    localparam int DIV_BITS     = 5;
    localparam int DIV_STEPS    = (SUM_W + DIV_BITS - 1) / DIV_BITS;
    localparam int DIV_PAD_W    = DIV_STEPS * DIV_BITS;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_BUCKET_COUNT   = 2'd0,
        REG_HASH_SCALE     = 2'd1,
        REG_MATCH_TOL      = 2'd2,
        REG_IGNORE_NORMALS = 2'd3
    } cfg_reg_t;

    localparam logic [BCNT_W-1:0]  BUCKET_COUNT_RST = BCNT_W'(1024);
    localparam logic [SCALE_W-1:0] HASH_SCALE_RST   = SCALE_W'(1024);
    localparam logic [TOL_W-1:0]   MATCH_TOL_RST    = TOL_W'(1);
    localparam logic               IGNORE_NORM_RST  = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic signed [COORD_W-1:0] norm_x;
        logic signed [COORD_W-1:0] norm_y;
        logic signed [COORD_W-1:0] norm_z;
        logic [NEXT_W-1:0]         next;
        logic [BKT_W-1:0]          bucket;
    } entry_t;

    typedef struct packed {
        logic             used;
        logic [IDX_W-1:0] head;
    } bucket_word_t;

    localparam int ENTRY_W  = $bits(entry_t);
    localparam int BWORD_W  = $bits(bucket_word_t);

endpackage

@@ design/vwh_if.sv @@
`timescale 1ns / 1ps
// Request channels of the vertex weld block: vertex input and weld result.
// Depends on vwh_pkg.
interface vwh_in_if;
    import vwh_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      start_mesh;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic signed [COORD_W-1:0] norm_x;
    logic signed [COORD_W-1:0] norm_y;
    logic signed [COORD_W-1:0] norm_z;

    modport source (output valid, start_mesh, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                    input ready);
    modport sink (input valid, start_mesh, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                  output ready);
endinterface

interface vwh_out_if;
    import vwh_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [OUT_IDX_W-1:0] vertex_index;
    logic                 is_new;
    logic                 store_full;

    modport source (output valid, vertex_index, is_new, store_full, input ready);
    modport sink (input valid, vertex_index, is_new, store_full, output ready);
endinterface

@@ design/vwh_ram.sv @@
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module vwh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

@@ design/vwh_mod.sv @@
`timescale 1ns / 1ps
// Iterative remainder unit: a shift-subtract loop retiring DIV_BITS bits a cycle.
// Depends on vwh_pkg.
module vwh_mod (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [vwh_pkg::SUM_W-1:0] dividend,
    input  logic [vwh_pkg::REM_W-1:0] divisor,
    output logic                     done,
    output logic [vwh_pkg::REM_W-1:0] remainder
);
    import vwh_pkg::*;

    logic [DIV_PAD_W-1:0] dvd_reg, dvd_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [REM_W-1:0]     div_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    // The partial remainder stays below the divisor, so one more bit fits in REM_W+1.
    always_comb
    begin
        logic [REM_W:0] trial;
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        for (int k = 0; k < DIV_BITS; k++)
        begin
            trial = {rem_next, dvd_next[DIV_PAD_W-1]};
            dvd_next = {dvd_next[DIV_PAD_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                trial = trial - {1'b0, div_reg};
            end
            rem_next = trial[REM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= DIV_PAD_W'(dividend);
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;
endmodule

@@ design/vertex_weld_hash_dedup.sv @@
`timescale 1ns / 1ps
// Top level of the vertex weld block: hash, bucket chain walk and insert.
// Depends on vwh_pkg, vwh_if, vwh_ram, vwh_mod and assert_macros.svh.
// Flow per request: sum, multiply, remainder, bucket head read and check, then a
// walk of the chain one entry at a time, and an insert when no entry matches; the
// remainder unit runs seven steps of DIV_BITS bits, then raises done.
// One request is handled at a time; a new one is taken only in the idle state.
// Reset: a clearing pass sweeps all 1024 bucket table words; no request is
// taken until it ends. Registers reset to their defaults and the store is empty.
`include "assert_macros.svh"

module vertex_weld_hash_dedup (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [vwh_pkg::CFG_ADDR_W-1:0] cfg_index,
    input  logic [vwh_pkg::CFG_DATA_W-1:0] cfg_data,
    vwh_in_if.sink                        in_ch,
    vwh_out_if.source                     out_ch
);
    import vwh_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_SUM, S_MUL, S_DIV, S_HEAD_RD, S_HEAD_CHK, S_WALK, S_INSERT
    } state_t;

    state_t state_reg;

    logic [BCNT_W-1:0]  bucket_count_reg;
    logic [SCALE_W-1:0] hash_scale_reg;
    logic [TOL_W-1:0]   match_tol_reg;
    logic               ignore_norm_reg;

    logic signed [COORD_W-1:0] px_reg, py_reg, pz_reg, nx_reg, ny_reg, nz_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  dividend_reg;
    logic [BKT_W-1:0]  bucket_reg;
    logic [BKT_W-1:0]  clr_cnt_reg;
    logic [NEXT_W-1:0] nfi_reg;
    logic [IDX_W-1:0]  cur_reg;
    logic [IDX_W-1:0]  head_reg;
    logic              head_valid_reg;
    logic              first_reg;

    logic                 out_valid_reg;
    logic [OUT_IDX_W-1:0] out_index_reg;
    logic                 is_new_reg;
    logic                 full_reg;

    logic [REM_W-1:0] divisor;
    logic [SUM_W-1:0] ax, ay, az;
    logic [SUM_W-1:0] sum_next;
    logic [PROD_W-1:0] prod;
    logic             mod_start;
    logic             mod_done;
    logic [REM_W-1:0] mod_rem;
    logic             out_free;
    logic             in_fire;

    bucket_word_t bkt_rdata, bkt_wdata;
    logic         bkt_we, bkt_re;
    logic [BKT_W-1:0] bkt_waddr;
    entry_t       ent_rdata, ent_wdata;
    logic         ent_we, ent_re;
    logic [IDX_W-1:0] ent_raddr;
    logic         ent_match;
    logic         chain_end;

    function automatic logic close_enough(logic signed [COORD_W-1:0] a,
                                          logic signed [COORD_W-1:0] b,
                                          logic [TOL_W-1:0] tol);
        logic signed [COORD_W:0] d;
        logic [COORD_W:0]        m;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        m = d[COORD_W] ? (COORD_W+1)'(-d) : (COORD_W+1)'(d);
        return m <= (COORD_W+1)'(tol);
    endfunction

    // Bucket counts outside 1..BUCKET_SLOTS are clamped.
    always_comb
    begin
        if (bucket_count_reg == '0)
        begin
            divisor = REM_W'(1);
        end
        else if (bucket_count_reg > BCNT_W'(BUCKET_SLOTS))
        begin
            divisor = REM_W'(BUCKET_SLOTS);
        end
        else
        begin
            divisor = REM_W'(bucket_count_reg);
        end
    end

    assign ax = SUM_W'(px_reg[COORD_W-1] ? -px_reg : px_reg);
    assign ay = SUM_W'(py_reg[COORD_W-1] ? -py_reg : py_reg);
    assign az = SUM_W'(pz_reg[COORD_W-1] ? -pz_reg : pz_reg);
    assign sum_next = ax + (ax << 1) + ay + (ay << 2) + (az << 3) - az;
    assign prod = PROD_W'(sum_reg) * PROD_W'(hash_scale_reg) + PROD_W'(32768);

    assign in_fire   = in_ch.valid && in_ch.ready;
    assign out_free  = !out_valid_reg || out_ch.ready;
    assign mod_start = (state_reg == S_MUL);

    assign in_ch.ready         = (state_reg == S_IDLE);
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.vertex_index = out_index_reg;
    assign out_ch.is_new       = is_new_reg;
    assign out_ch.store_full   = full_reg;

    assign ent_match = close_enough(ent_rdata.pos_x, px_reg, match_tol_reg)
                    && close_enough(ent_rdata.pos_y, py_reg, match_tol_reg)
                    && close_enough(ent_rdata.pos_z, pz_reg, match_tol_reg)
                    && (ignore_norm_reg
                        || (close_enough(ent_rdata.norm_x, nx_reg, match_tol_reg)
                            && close_enough(ent_rdata.norm_y, ny_reg, match_tol_reg)
                            && close_enough(ent_rdata.norm_z, nz_reg, match_tol_reg)));
    assign chain_end = (ent_rdata.next >= NEXT_W'(MAX_VERTICES)) || (ent_rdata.next >= nfi_reg);

    // A stale head from an earlier mesh is caught by the bucket tag of the entry it names.
    always_comb
    begin
        bkt_re    = (state_reg == S_HEAD_RD);
        bkt_we    = 1'b0;
        bkt_waddr = bucket_reg;
        bkt_wdata = '{used: 1'b1, head: nfi_reg[IDX_W-1:0]};
        ent_we    = 1'b0;
        ent_re    = 1'b0;
        ent_raddr = bkt_rdata.head;
        ent_wdata = '{pos_x: px_reg, pos_y: py_reg, pos_z: pz_reg,
                      norm_x: ignore_norm_reg ? '0 : nx_reg,
                      norm_y: ignore_norm_reg ? '0 : ny_reg,
                      norm_z: ignore_norm_reg ? '0 : nz_reg,
                      next: head_valid_reg ? {1'b0, head_reg} : NEXT_W'(MAX_VERTICES),
                      bucket: bucket_reg};
        case (state_reg)
            S_CLEAR:
            begin
                bkt_we    = 1'b1;
                bkt_waddr = clr_cnt_reg;
                bkt_wdata = '0;
            end
            S_HEAD_CHK:
            begin
                ent_re = bkt_rdata.used && ({1'b0, bkt_rdata.head} < nfi_reg);
            end
            S_WALK:
            begin
                ent_raddr = ent_rdata.next[IDX_W-1:0];
                ent_re    = out_free && !(first_reg && ent_rdata.bucket != bucket_reg)
                         && !ent_match && !chain_end;
            end
            S_INSERT:
            begin
                bkt_we = out_free && (nfi_reg < NEXT_W'(MAX_VERTICES));
                ent_we = bkt_we;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_cnt_reg      <= '0;
            nfi_reg          <= '0;
            out_valid_reg    <= 1'b0;
            bucket_count_reg <= BUCKET_COUNT_RST;
            hash_scale_reg   <= HASH_SCALE_RST;
            match_tol_reg    <= MATCH_TOL_RST;
            ignore_norm_reg  <= IGNORE_NORM_RST;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_BUCKET_COUNT:   bucket_count_reg <= cfg_data[BCNT_W-1:0];
                    REG_HASH_SCALE:     hash_scale_reg   <= cfg_data[SCALE_W-1:0];
                    REG_MATCH_TOL:      match_tol_reg    <= cfg_data[TOL_W-1:0];
                    REG_IGNORE_NORMALS: ignore_norm_reg  <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end

            if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == BKT_W'(BUCKET_SLOTS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (in_ch.start_mesh)
                        begin
                            nfi_reg <= '0;
                        end
                        state_reg <= S_SUM;
                    end
                end
                S_SUM:
                begin
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (mod_done)
                    begin
                        state_reg <= S_HEAD_RD;
                    end
                end
                S_HEAD_RD:
                begin
                    state_reg <= S_HEAD_CHK;
                end
                S_HEAD_CHK:
                begin
                    state_reg <= ent_re ? S_WALK : S_INSERT;
                end
                S_WALK:
                begin
                    if (first_reg && ent_rdata.bucket != bucket_reg)
                    begin
                        state_reg <= S_INSERT;
                    end
                    else if (ent_match)
                    begin
                        if (out_free)
                        begin
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                    end
                    else if (chain_end)
                    begin
                        state_reg <= S_INSERT;
                    end
                end
                S_INSERT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                        if (nfi_reg < NEXT_W'(MAX_VERTICES))
                        begin
                            nfi_reg <= nfi_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers that need no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            px_reg <= in_ch.pos_x;
            py_reg <= in_ch.pos_y;
            pz_reg <= in_ch.pos_z;
            nx_reg <= in_ch.norm_x;
            ny_reg <= in_ch.norm_y;
            nz_reg <= in_ch.norm_z;
        end
        if (state_reg == S_SUM)
        begin
            sum_reg <= sum_next;
        end
        if (state_reg == S_MUL)
        begin
            dividend_reg <= prod[PROD_W-1:ROUND_SHIFT];
        end
        if (state_reg == S_DIV && mod_done)
        begin
            bucket_reg <= mod_rem[BKT_W-1:0];
        end
        if (state_reg == S_HEAD_CHK)
        begin
            head_reg       <= bkt_rdata.head;
            head_valid_reg <= ent_re;
            cur_reg        <= bkt_rdata.head;
            first_reg      <= 1'b1;
        end
        if (state_reg == S_WALK)
        begin
            if (first_reg && ent_rdata.bucket != bucket_reg)
            begin
                head_valid_reg <= 1'b0;
            end
            if (ent_re)
            begin
                cur_reg   <= ent_rdata.next[IDX_W-1:0];
                first_reg <= 1'b0;
            end
            if (ent_match && out_free && !(first_reg && ent_rdata.bucket != bucket_reg))
            begin
                out_index_reg <= OUT_IDX_W'(cur_reg);
                is_new_reg    <= 1'b0;
                full_reg      <= 1'b0;
            end
        end
        if (state_reg == S_INSERT && out_free)
        begin
            if (nfi_reg < NEXT_W'(MAX_VERTICES))
            begin
                out_index_reg <= OUT_IDX_W'(nfi_reg);
                is_new_reg    <= 1'b1;
                full_reg      <= 1'b0;
            end
            else
            begin
                out_index_reg <= '0;
                is_new_reg    <= 1'b0;
                full_reg      <= 1'b1;
            end
        end
    end

    vwh_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (prod[PROD_W-1:ROUND_SHIFT]),
        .divisor   (divisor),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    vwh_ram #(
        .WIDTH (BWORD_W),
        .DEPTH (BUCKET_SLOTS)
    ) u_bucket_ram (
        .clk   (clk),
        .we    (bkt_we),
        .waddr (bkt_waddr),
        .wdata (bkt_wdata),
        .re    (bkt_re),
        .raddr (bucket_reg),
        .rdata (bkt_rdata)
    );

    vwh_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_VERTICES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (nfi_reg[IDX_W-1:0]),
        .wdata (ent_wdata),
        .re    (ent_re),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    `VWH_ASSERT_NOW(a_flags_exclusive, out_valid_reg, !(is_new_reg && full_reg), "new and full together")
    `VWH_ASSERT_NOW(a_fill_bound, 1'b1, nfi_reg <= NEXT_W'(MAX_VERTICES), "fill count overflow")
    `VWH_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ch.ready, "request taken while busy")
    `VWH_ASSERT_NOW(a_bucket_range, state_reg == S_HEAD_RD, {1'b0, bucket_reg} < divisor, "bucket out of range")
    `VWH_ASSERT_NOW(a_dividend_match, state_reg == S_HEAD_RD, dividend_reg <= sum_reg, "hash above sum bound")
endmodule

@@ tb/tb_vwh_channels.sv @@
`timescale 1ns / 1ps
// Testbench notes for the vertex weld channels.
// The request channels themselves come from design/vwh_if.sv (vwh_in_if, vwh_out_if).
package tb_vwh_types;
    import vwh_pkg::*;

    typedef struct {
        logic [OUT_IDX_W-1:0] vertex_index;
        logic                 is_new;
        logic                 store_full;
    } weld_result_t;
endpackage

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Testbench of vertex_weld_hash_dedup: drives vertices and register writes, predicts
// each weld result with its own hash table and checks every result in order.
// Depends on vwh_pkg, vwh_if and tb_vwh_types.
module tb;
    import vwh_pkg::*;
    import tb_vwh_types::*;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int errors;

    vwh_in_if  in_ch();
    vwh_out_if out_ch();

    vertex_weld_hash_dedup dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    class weld_board;
        int unsigned n_buckets;
        longint unsigned scale;
        longint unsigned tol;
        bit no_normals;
        bit               used [BUCKET_SLOTS];
        int unsigned      head [BUCKET_SLOTS];
        int unsigned      link [MAX_VERTICES];
        longint           comp [MAX_VERTICES][6];
        int unsigned      fill;
        weld_result_t     pending[$];

        function new();
            n_buckets = 1024; scale = 1024; tol = 1; no_normals = 1;
            fill = 0;
            foreach (used[i]) used[i] = 0;
        endfunction

        function void set_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
            case (r)
                REG_BUCKET_COUNT:   n_buckets = v[BCNT_W-1:0];
                REG_HASH_SCALE:     scale = v;
                REG_MATCH_TOL:      tol = v;
                REG_IGNORE_NORMALS: no_normals = v[0];
                default:
                begin
                end
            endcase
        endfunction

        function bit near(longint a, longint b);
            longint d;
            d = a - b;
            if (d < 0) d = -d;
            return longint'(d) <= longint'(tol);
        endfunction

        function void note_vertex(bit start, longint c[6]);
            longint unsigned sum, div, bkt;
            longint a;
            int unsigned cur;
            bit hit;
            weld_result_t r;
            if (start)
            begin
                foreach (used[i]) used[i] = 0;
                fill = 0;
            end
            div = n_buckets == 0 ? 1 : (n_buckets > BUCKET_SLOTS ? BUCKET_SLOTS : n_buckets);
            sum = 0;
            for (int k = 0; k < 3; k++)
            begin
                a = c[k] < 0 ? -c[k] : c[k];
                sum += (3 + 2 * k) * a;
            end
            bkt = ((sum * scale + 32768) >> 16) % div;
            hit = 0;
            cur = head[bkt];
            if (used[bkt])
                while (!hit && cur < fill)
                begin
                    hit = 1;
                    for (int k = 0; k < 6; k++)
                        if ((k < 3 || !no_normals) && !near(comp[cur][k], c[k])) hit = 0;
                    if (!hit)
                    begin
                        if (link[cur] >= MAX_VERTICES) break;
                        cur = link[cur];
                    end
                end
            if (hit)
            begin
                r.vertex_index = cur; r.is_new = 0; r.store_full = 0;
            end
            else if (fill >= MAX_VERTICES)
            begin
                r.vertex_index = 0; r.is_new = 0; r.store_full = 1;
            end
            else
            begin
                for (int k = 0; k < 6; k++) comp[fill][k] = (k >= 3 && no_normals) ? 0 : c[k];
                link[fill] = used[bkt] ? head[bkt] : MAX_VERTICES;
                head[bkt] = fill;
                used[bkt] = 1;
                r.vertex_index = fill[OUT_IDX_W-1:0]; r.is_new = 1; r.store_full = 0;
                fill++;
            end
            pending.push_back(r);
        endfunction

        task check_result(logic [OUT_IDX_W-1:0] idx, logic nw, logic full);
            weld_result_t w;
            if (pending.size() == 0)
            begin
                report("unexpected result", idx, -1);
                return;
            end
            w = pending.pop_front();
            if (idx !== w.vertex_index) report("vertex_index", idx, w.vertex_index);
            if (nw !== w.is_new) report("is_new", nw, w.is_new);
            if (full !== w.store_full) report("store_full", full, w.store_full);
        endtask
    endclass

    weld_board board;
    int send_idle, recv_idle;
    int hold_off;

    always
    begin
        clk = 1'b0; #10;
        clk = 1'b1; #10;
    end

    initial
    begin
        #200_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Result side: random back-pressure plus a long counted hold-off when asked.
    always @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready && rst_n)
            board.note_vertex(in_ch.start_mesh, '{in_ch.pos_x, in_ch.pos_y, in_ch.pos_z,
                in_ch.norm_x, in_ch.norm_y, in_ch.norm_z});
        if (out_ch.valid && out_ch.ready && rst_n)
            board.check_result(out_ch.vertex_index, out_ch.is_new, out_ch.store_full);
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle);
    end

    task automatic write_reg(cfg_reg_t r, int v);
        cfg_we <= 1'b1; cfg_index <= r; cfg_data <= v;
        board.set_reg(r, v);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic int coord(int mode);
        case (mode)
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 0;
            3: return $urandom_range(7) - 3;
            default: return $urandom;
        endcase
    endfunction

    // The request stays valid after acceptance until the next idle cycle or drain.
    task automatic send(bit start, int px, int py, int pz, int nx, int ny, int nz);
        while ($urandom_range(99) < send_idle)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1; in_ch.start_mesh <= start;
        in_ch.pos_x <= px; in_ch.pos_y <= py; in_ch.pos_z <= pz;
        in_ch.norm_x <= nx; in_ch.norm_y <= ny; in_ch.norm_z <= nz;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
    endtask

    // Random vertex: mostly a near copy of an earlier one so chains get walked.
    int hx[$], hy[$], hz[$];
    task automatic send_random();
        int px, py, pz, j;
        bit start;
        start = ($urandom_range(99) == 0);
        if (hx.size() != 0 && $urandom_range(99) < 55)
        begin
            j = $urandom_range(hx.size() - 1);
            px = hx[j] + $urandom_range(4) - 2;
            py = hy[j] + $urandom_range(4) - 2;
            pz = hz[j];
        end
        else
        begin
            px = coord($urandom_range(9)); py = coord($urandom_range(9));
            pz = coord($urandom_range(9));
            hx.push_back(px); hy.push_back(py); hz.push_back(pz);
        end
        send(start, px, py, pz, coord($urandom_range(3, 4)), coord($urandom_range(3, 4)),
             coord($urandom_range(3, 4)));
    endtask

    initial
    begin
        board = new();
        errors = 0; hold_off = 0;
        send_idle = 14; recv_idle = 78;
        rst_n = 1'b0; cfg_we = 1'b0; cfg_index = REG_BUCKET_COUNT; cfg_data = '0;
        in_ch.valid = 1'b0; in_ch.start_mesh = 1'b0;
        in_ch.pos_x = 0; in_ch.pos_y = 0; in_ch.pos_z = 0;
        in_ch.norm_x = 0; in_ch.norm_y = 0; in_ch.norm_z = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: coordinate extremes, duplicates, tolerance edges, normals on.
        send(1, 32'h8000_0000, 32'h7FFF_FFFF, 0, -1, -1, -1);
        send(0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 5, 6, 7);
        send(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
        send(0, 100, 200, 300, 0, 0, 0);
        send(0, 101, 199, 301, 0, 0, 0);
        send(0, 102, 200, 300, 0, 0, 0);
        drain();
        write_reg(REG_IGNORE_NORMALS, 0);
        write_reg(REG_MATCH_TOL, 0);
        write_reg(REG_BUCKET_COUNT, 1);
        write_reg(REG_HASH_SCALE, 65535);
        send(0, 100, 200, 300, 1, 0, 0);     // stored normal of entry was zeroed
        send(0, 100, 200, 300, 0, 0, 0);
        send(0, 100, 200, 300, 9, 9, 9);
        send(0, 100, 200, 300, 9, 9, 9);
        send(1, -5, -5, -5, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        send(0, -5, -5, -5, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        drain();
        write_reg(REG_BUCKET_COUNT, 0);      // acts as one bucket
        write_reg(REG_MATCH_TOL, 65535);
        send(1, 0, 0, 0, 0, 0, 0);
        send(0, 65535, -65535, 0, 65535, 0, 0);
        send(0, 65536, 0, 0, 0, 0, 0);
        drain();
        write_reg(REG_BUCKET_COUNT, 2047);   // clamps to the full table
        write_reg(REG_HASH_SCALE, 1);
        write_reg(REG_IGNORE_NORMALS, 1);
        write_reg(REG_MATCH_TOL, 3);
        send(1, 7, 7, 7, 0, 0, 0);
        send(0, 8, 6, 7, 0, 0, 0);
        drain();

        // Long receiver hold-off while the sender keeps offering requests.
        hold_off = 400;
        for (int i = 0; i < 30; i++) send_random();
        drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            if (ph == 1) begin send_idle = 78; recv_idle = 14; end
            if (ph == 2) begin send_idle = 0; recv_idle = 0; end
            write_reg(REG_BUCKET_COUNT, $urandom_range(1, 1024));
            write_reg(REG_HASH_SCALE, $urandom_range(1, 65535));
            write_reg(REG_MATCH_TOL, $urandom_range(0, 4));
            write_reg(REG_IGNORE_NORMALS, $urandom_range(1));
            for (int i = 0; i < 180; i++) send_random();
            drain();
        end

        // Fill the store with distinct vertices to reach the full condition.
        write_reg(REG_BUCKET_COUNT, 1024);
        write_reg(REG_HASH_SCALE, 65535);
        write_reg(REG_MATCH_TOL, 0);
        write_reg(REG_IGNORE_NORMALS, 1);
        for (int i = 0; i < MAX_VERTICES + 3; i++)
            send(i == 0, i * 7919, i, -i, 0, 0, 0);
        send(0, 7919, 1, -1, 0, 0, 0);
        drain();

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
